### hw/rtl/lccd_pkg.sv
`default_nettype none

package lccd_pkg;

  // result event codes
  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_STORED   = 4'd1;
  localparam logic [3:0] EV_REPEAT   = 4'd2;
  localparam logic [3:0] EV_MSG      = 4'd3;
  localparam logic [3:0] EV_BAD_SYNC = 4'd4;
  localparam logic [3:0] EV_PAIR1    = 4'd5;
  localparam logic [3:0] EV_PAIR2    = 4'd6;
  localparam logic [3:0] EV_PAIR3    = 4'd7;
  localparam logic [3:0] EV_PAIR4    = 4'd8;
  localparam logic [3:0] EV_RANGE    = 4'd9;

  localparam logic [11:0] MAX_LEN      = 12'd16;
  localparam logic [3:0]  GROUP_LEN    = 4'd10;
  localparam logic [5:0]  PAIR_SUM     = 6'd15;
  localparam logic [7:0]  CRC_POLY     = 8'h8C;
  localparam logic [8:0]  MAX_EMIT_IDX = 9'd63;

  typedef struct packed {
    logic       capture;
    logic       sync_step;
    logic       rd_pos;
    logic       rd_cnt;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       crc_acc;
    logic       store_wr;
    logic       set_finished;
    logic       out_load;
    logic       out_last;
    logic [3:0] out_ev;
  } lccd_cmd_t;

  typedef struct packed {
    logic       skip;
    logic       grp;
    logic [3:0] dec_ev;
    logic       rpt_hit;
    logic       crc_end;
    logic       crc_match;
    logic       emit_last;
    logic       out_free;
  } lccd_sts_t;

  // one byte of reflected crc-8
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] din);
    logic [7:0] c;
    c = crc ^ din;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/lccd_ctrl.sv
`default_nettype none

module lccd_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire lccd_pkg::lccd_sts_t sts_i,
  output lccd_pkg::lccd_cmd_t     cmd_o
);
  import lccd_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SYNC    = 9'b000000010,
    S_DEC     = 9'b000000100,
    S_CMP     = 9'b000001000,
    S_CRC_RD  = 9'b000010000,
    S_CRC_ACC = 9'b000100000,
    S_EM_RD   = 9'b001000000,
    S_EM_WR   = 9'b010000000,
    S_RESP    = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] ev_q, ev_d;

  always_comb begin
    state_d    = state_q;
    ev_d       = ev_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_SYNC;
        end
      end
      S_SYNC: begin
        ev_d = EV_NONE;
        if (sts_i.skip) begin
          state_d = S_RESP;
        end else begin
          cmd_o.sync_step = 1'b1;
          state_d         = sts_i.grp ? S_DEC : S_RESP;
        end
      end
      S_DEC: begin
        cmd_o.rd_pos = 1'b1;
        state_d      = S_CMP;
      end
      S_CMP: begin
        priority if (sts_i.dec_ev != EV_NONE) begin
          ev_d    = sts_i.dec_ev;
          state_d = S_RESP;
        end else if (sts_i.rpt_hit) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_CRC_RD;
        end else begin
          cmd_o.store_wr = 1'b1;
          ev_d           = EV_STORED;
          state_d        = S_RESP;
        end
      end
      S_CRC_RD: begin
        cmd_o.rd_cnt = 1'b1;
        state_d      = S_CRC_ACC;
      end
      S_CRC_ACC: begin
        priority if (sts_i.crc_end && sts_i.crc_match) begin
          cmd_o.set_finished = 1'b1;
          cmd_o.cnt_clr      = 1'b1;
          state_d            = S_EM_RD;
        end else if (sts_i.crc_end) begin
          ev_d    = EV_REPEAT;
          state_d = S_RESP;
        end else begin
          cmd_o.crc_acc = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_CRC_RD;
        end
      end
      S_EM_RD: begin
        cmd_o.rd_cnt = 1'b1;
        state_d      = S_EM_WR;
      end
      S_EM_WR: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_ev   = EV_MSG;
          cmd_o.out_last = sts_i.emit_last;
          cmd_o.cnt_inc  = 1'b1;
          state_d        = sts_i.emit_last ? S_IDLE : S_EM_RD;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_ev   = ev_q;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ev_q    <= EV_NONE;
    end else begin
      state_q <= state_d;
      ev_q    <= ev_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded into a full output stage");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load && cmd_o.out_last |=> in_ready_o)
    else $error("controller not idle after final result of a transaction");

endmodule

`default_nettype wire

### hw/rtl/lccd_dpath.sv
`default_nettype none

module lccd_dpath #(
  parameter int MSG_DEPTH = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [47:0]         src_mac_i,
  input  wire logic [11:0]         frame_len_i,
  input  wire logic [3:0]          channel_i,
  input  wire lccd_pkg::lccd_cmd_t cmd_i,
  output lccd_pkg::lccd_sts_t      sts_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [3:0]               event_res_o,
  output logic [5:0]               position_o,
  output logic [7:0]               value_o,
  output logic [5:0]               message_length_o,
  output logic                     last_o,
  output logic                     locked_o,
  output logic [3:0]               locked_channel_o
);
  import lccd_pkg::*;

  localparam int AW = $clog2(MSG_DEPTH);
  localparam logic [8:0] DepthW = 9'(MSG_DEPTH);

  typedef enum logic [2:0] {
    SY_HUNT = 3'b001,
    SY_SYNC = 3'b010,
    SY_COLL = 3'b100
  } sync_e;

  // captured transaction
  logic [47:0] mac_q;
  logic [11:0] len_q;
  logic [3:0]  ch_q;

  // sync tracking
  sync_e       sst_q, sst_d;
  logic [3:0]  scnt_q, scnt_d;
  logic [4:0]  sym_q [10];
  logic        sym_we;
  logic [3:0]  sym_idx;
  logic [4:0]  sym_wd;
  logic [47:0] stn_q, stn_d;
  logic [3:0]  chan_q, chan_d;
  logic        lock_q;
  logic        finished_q;
  logic        grp;
  logic        start;

  // message store
  logic [7:0]    mem [MSG_DEPTH];
  logic          vld_q [MSG_DEPTH];
  logic [7:0]    rd_q;
  logic          rd_vld_q;
  logic [AW-1:0] raddr;
  logic [7:0]    rd_byte;
  logic [AW-1:0] hp_q;
  logic [AW-1:0] cnt_q;
  logic [7:0]    crc_q;

  // decode
  logic [4:0] red [8];
  logic [3:0] pair_ok;
  logic [7:0] dec_pos;
  logic [7:0] dec_val;
  logic [3:0] dec_ev;
  logic       in_range;

  // output stage
  logic       ov_q;
  logic [3:0] o_ev_q;
  logic [5:0] o_pos_q, o_pos_d;
  logic [7:0] o_val_q, o_val_d;
  logic [5:0] o_mlen_q;
  logic       o_last_q;
  logic       o_lock_q;
  logic [3:0] o_chan_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mac_q <= src_mac_i;
      len_q <= frame_len_i;
      ch_q  <= channel_i;
    end
  end

  always_comb begin
    sst_d   = sst_q;
    scnt_d  = scnt_q;
    sym_we  = 1'b0;
    sym_idx = scnt_q;
    sym_wd  = len_q[4:0];
    stn_d   = stn_q;
    chan_d  = chan_q;
    start   = 1'b0;
    grp     = 1'b0;
    unique case (sst_q)
      SY_HUNT: begin
        if (len_q == 12'd0) start = 1'b1;
      end
      SY_SYNC: begin
        if (mac_q == stn_q) begin
          if (len_q == 12'd0) begin
            sym_we = 1'b1;
            sym_wd = 5'd0;
            scnt_d = scnt_q + 4'd1;
            sst_d  = SY_COLL;
          end else begin
            sst_d  = SY_HUNT;
            scnt_d = 4'd0;
          end
        end
      end
      SY_COLL: begin
        if (mac_q == stn_q) begin
          if (len_q == 12'd0) begin
            start = 1'b1;
          end else begin
            sym_we = 1'b1;
            scnt_d = scnt_q + 4'd1;
          end
        end
      end
      default: begin
        sst_d  = SY_HUNT;
        scnt_d = 4'd0;
      end
    endcase
    if (start) begin
      // sender address stays once a byte has been stored
      if (!lock_q) stn_d = mac_q;
      chan_d  = ch_q;
      sym_we  = 1'b1;
      sym_idx = 4'd0;
      sym_wd  = 5'd0;
      scnt_d  = 4'd1;
      sst_d   = SY_SYNC;
    end
    if (scnt_d >= GROUP_LEN) begin
      grp    = 1'b1;
      scnt_d = 4'd0;
      sst_d  = SY_HUNT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sync_step && sym_we) sym_q[sym_idx] <= sym_wd;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      red[i] = sym_q[i + 2] - 5'd1;
    end
    for (int j = 0; j < 4; j++) begin
      pair_ok[j] = (6'(red[2 * j]) + 6'(red[2 * j + 1])) == PAIR_SUM;
    end
    dec_pos  = {red[2][3:0], red[0][3:0]};
    dec_val  = {red[6][3:0], red[4][3:0]};
    in_range = {1'b0, dec_pos} < DepthW;
    priority if (sym_q[0] != 5'd0 || sym_q[1] != 5'd0) dec_ev = EV_BAD_SYNC;
    else if (!pair_ok[0]) dec_ev = EV_PAIR1;
    else if (!pair_ok[1]) dec_ev = EV_PAIR2;
    else if (!pair_ok[2]) dec_ev = EV_PAIR3;
    else if (!pair_ok[3]) dec_ev = EV_PAIR4;
    else if (!in_range)   dec_ev = EV_RANGE;
    else                  dec_ev = EV_NONE;
  end

  assign raddr   = cmd_i.rd_pos ? AW'(dec_pos) : cnt_q;
  assign rd_byte = rd_vld_q ? rd_q : 8'h00;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) mem[AW'(dec_pos)] <= dec_val;
    if (cmd_i.rd_pos || cmd_i.rd_cnt) begin
      rd_q     <= mem[raddr];
      rd_vld_q <= vld_q[raddr];
    end
  end

  // entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MSG_DEPTH; k++) vld_q[k] <= 1'b0;
    end else if (cmd_i.store_wr) begin
      vld_q[AW'(dec_pos)] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sst_q      <= SY_HUNT;
      scnt_q     <= 4'd0;
      stn_q      <= 48'd0;
      chan_q     <= 4'd0;
      lock_q     <= 1'b0;
      finished_q <= 1'b0;
      hp_q       <= '0;
      cnt_q      <= '0;
      crc_q      <= 8'h00;
    end else begin
      if (cmd_i.sync_step) begin
        sst_q  <= sst_d;
        scnt_q <= scnt_d;
        stn_q  <= stn_d;
        chan_q <= chan_d;
      end
      if (cmd_i.store_wr) begin
        lock_q <= 1'b1;
        if (AW'(dec_pos) > hp_q) hp_q <= AW'(dec_pos);
      end
      if (cmd_i.set_finished) finished_q <= 1'b1;
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
        crc_q <= 8'h00;
      end else begin
        if (cmd_i.cnt_inc) cnt_q <= cnt_q + 1'b1;
        if (cmd_i.crc_acc) crc_q <= crc8_step(crc_q, rd_byte);
      end
    end
  end

  always_comb begin
    sts_o.skip      = finished_q || (len_q > MAX_LEN);
    sts_o.grp       = grp;
    sts_o.dec_ev    = dec_ev;
    sts_o.rpt_hit   = (rd_byte == dec_val) && (hp_q > AW'(2));
    sts_o.crc_end   = cnt_q == hp_q;
    sts_o.crc_match = crc_q == rd_byte;
    sts_o.emit_last = (cnt_q == AW'(hp_q - 1'b1)) || (9'(cnt_q) == MAX_EMIT_IDX);
    sts_o.out_free  = !ov_q || out_ready_i;
  end

  always_comb begin
    unique case (cmd_i.out_ev)
      EV_STORED, EV_REPEAT: begin
        o_pos_d = dec_pos[5:0];
        o_val_d = dec_val;
      end
      EV_MSG: begin
        o_pos_d = 6'(cnt_q);
        o_val_d = rd_byte;
      end
      default: begin
        o_pos_d = 6'd0;
        o_val_d = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      o_ev_q   <= cmd_i.out_ev;
      o_pos_q  <= o_pos_d;
      o_val_q  <= o_val_d;
      o_mlen_q <= 6'(hp_q);
      o_last_q <= cmd_i.out_last;
      o_lock_q <= lock_q;
      o_chan_q <= chan_q;
    end
  end

  assign out_valid_o      = ov_q;
  assign event_res_o      = o_ev_q;
  assign position_o       = o_pos_q;
  assign value_o          = o_val_q;
  assign message_length_o = o_mlen_q;
  assign last_o           = o_last_q;
  assign locked_o         = o_lock_q;
  assign locked_channel_o = o_chan_q;

  a_store_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store_wr |-> in_range && !finished_q)
    else $error("store write out of range or after message completed");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_cnt |-> cnt_q <= hp_q)
    else $error("store walk beyond highest position");

  a_hp_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> hp_q >= $past(hp_q))
    else $error("highest position went backwards");

endmodule

`default_nettype wire

### hw/rtl/length_coded_config_decoder.sv
// length-coded config decoder
// input channel: one transaction per sniffed frame (sender address, payload
// length, channel), valid/ready. output channel: one or more results per input
// transaction, valid/ready, last marks the final result of that transaction.
// an input transaction is taken only while the controller is idle; one sits in
// the block at a time.
// a frame that completes no group passes the sync and result states, and the
// controller is back in idle as its result is registered; a completed group
// adds a decode and a store read before the result.
// a repeated value walks the message store from position 0 up to the highest
// position, reading each byte over the single store read port and folding it
// into the crc; after a crc match the bytes below the highest position follow,
// each once the output register is free, at most 63 of them.
// a single output register parts the two sides: the next transaction may be
// accepted while a result waits; when the receiver stalls the controller
// holds in its result or message-emit state and no further input is taken.
// reset returns sync to hunting, clears the station address, lock, channel
// and highest position, and marks every store entry unwritten (reads as zero)
// in the same cycle; no clearing pass is needed.
`default_nettype none

module length_coded_config_decoder #(
  parameter int MSG_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [47:0] src_mac_i,
  input  wire logic [11:0] frame_len_i,
  input  wire logic [3:0]  channel_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       event_res_o,
  output logic [5:0]       position_o,
  output logic [7:0]       value_o,
  output logic [5:0]       message_length_o,
  output logic             last_o,
  output logic             locked_o,
  output logic [3:0]       locked_channel_o
);
  import lccd_pkg::*;

  lccd_cmd_t cmd;
  lccd_sts_t sts;

  lccd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lccd_dpath #(
    .MSG_DEPTH (MSG_DEPTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .src_mac_i        (src_mac_i),
    .frame_len_i      (frame_len_i),
    .channel_i        (channel_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_res_o      (event_res_o),
    .position_o       (position_o),
    .value_o          (value_o),
    .message_length_o (message_length_o),
    .last_o           (last_o),
    .locked_o         (locked_o),
    .locked_channel_o (locked_channel_o)
  );

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import lccd_pkg::*;

  localparam int STORE_DEPTH   = 64;
  localparam int RANDOM_FRAMES = 280;
  localparam int MAX_IDLE      = 5;
  localparam int TAIL_CYCLES   = 40;
  localparam int CYCLE_LIMIT   = 200000;

  typedef enum logic [1:0] {HUNTING, SYNCING, COLLECTING} sync_phase_e;

  typedef struct packed {
    logic [3:0] ev;
    logic [5:0] pos;
    logic [7:0] val;
    logic [5:0] msg_len;
    logic       last;
    logic       locked;
    logic [3:0] chan;
  } result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [47:0] src_mac_i   = '0;
  logic [11:0] frame_len_i = '0;
  logic [3:0]  channel_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  logic [3:0]  event_res_o;
  logic [5:0]  position_o;
  logic [7:0]  value_o;
  logic [5:0]  message_length_o;
  logic        last_o;
  logic        locked_o;
  logic [3:0]  locked_channel_o;

  length_coded_config_decoder #(
    .MSG_DEPTH(STORE_DEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .src_mac_i       (src_mac_i),
    .frame_len_i     (frame_len_i),
    .channel_i       (channel_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_res_o     (event_res_o),
    .position_o      (position_o),
    .value_o         (value_o),
    .message_length_o(message_length_o),
    .last_o          (last_o),
    .locked_o        (locked_o),
    .locked_channel_o(locked_channel_o)
  );

  // shadow copy of the decoder state
  sync_phase_e phase_q;
  logic [3:0]  sym_cnt_q;
  logic [4:0]  sym_q [16];
  logic [47:0] station_q;
  logic        locked_q;
  logic [3:0]  sync_ch_q;
  logic [7:0]  store_q [STORE_DEPTH];
  logic [5:0]  highest_q;
  logic        done_q;

  result_t     decoded_q [$];
  logic [47:0] home_mac;
  int          n_errors   = 0;
  int          n_frames   = 0;
  int          cycles     = 0;
  int          send_burst = 0;
  int          recv_burst = 0;
  int          recv_hold  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // idle cycles for one transaction, with stretches of none
  task automatic draw_idle(inout int burst, output int idle);
    if (burst > 0) begin
      burst--;
      idle = 0;
    end else begin
      idle = $urandom_range(0, MAX_IDLE);
      if ($urandom_range(0, 29) == 0) burst = $urandom_range(8, 40);
    end
  endtask

  task automatic reset_shadow();
    phase_q   = HUNTING;
    sym_cnt_q = '0;
    station_q = '0;
    locked_q  = 1'b0;
    sync_ch_q = '0;
    highest_q = '0;
    done_q    = 1'b0;
    foreach (sym_q[i]) sym_q[i] = '0;
    foreach (store_q[i]) store_q[i] = '0;
  endtask

  // reflected crc-8 over the stored bytes below count
  function automatic logic [7:0] crc8_over(input int unsigned count);
    logic [7:0] crc;
    crc = '0;
    for (int i = 0; i < count && i < STORE_DEPTH; i++) begin
      crc = crc ^ store_q[i];
      repeat (8) crc = crc[0] ? ({1'b0, crc[7:1]} ^ CRC_POLY) : {1'b0, crc[7:1]};
    end
    return crc;
  endfunction

  function automatic result_t make_result(input logic [3:0] ev, input logic [5:0] pos,
                                          input logic [7:0] val);
    result_t r;
    r.ev      = ev;
    r.pos     = pos;
    r.val     = val;
    r.msg_len = highest_q;
    r.last    = 1'b0;
    r.locked  = locked_q;
    r.chan    = sync_ch_q;
    return r;
  endfunction

  // {sum ok, nibble} for the pair starting at idx
  function automatic logic [4:0] pair_check(input int idx);
    logic [7:0] a;
    logic [7:0] b;
    a = {3'b000, sym_q[idx]} - 8'd1;
    b = {3'b000, sym_q[idx + 1]} - 8'd1;
    return {(9'(a) + 9'(b)) == 9'(PAIR_SUM), a[3:0]};
  endfunction

  task automatic push_symbol(input logic [4:0] sym);
    sym_q[sym_cnt_q] = sym;
    sym_cnt_q++;
  endtask

  task automatic begin_sync(input logic [47:0] mac, input logic [3:0] ch);
    if (!locked_q) station_q = mac;
    sync_ch_q = ch;
    sym_cnt_q = '0;
    push_symbol(5'd0);
    phase_q = SYNCING;
  endtask

  task automatic decode_group();
    logic [4:0] p1;
    logic [4:0] p2;
    logic [4:0] p3;
    logic [4:0] p4;
    logic [7:0] pos;
    logic [7:0] val;
    p1  = pair_check(2);
    p2  = pair_check(4);
    p3  = pair_check(6);
    p4  = pair_check(8);
    pos = {p2[3:0], p1[3:0]};
    val = {p4[3:0], p3[3:0]};
    if (sym_q[0] != '0 || sym_q[1] != '0) decoded_q.push_back(make_result(EV_BAD_SYNC, '0, '0));
    else if (!p1[4]) decoded_q.push_back(make_result(EV_PAIR1, '0, '0));
    else if (!p2[4]) decoded_q.push_back(make_result(EV_PAIR2, '0, '0));
    else if (!p3[4]) decoded_q.push_back(make_result(EV_PAIR3, '0, '0));
    else if (!p4[4]) decoded_q.push_back(make_result(EV_PAIR4, '0, '0));
    else if (pos >= STORE_DEPTH) decoded_q.push_back(make_result(EV_RANGE, '0, '0));
    else if (store_q[pos[5:0]] == val && highest_q > 6'd2) begin
      if (crc8_over(highest_q) == store_q[highest_q]) begin
        for (int i = 0; i < highest_q; i++) begin
          decoded_q.push_back(make_result(EV_MSG, 6'(i), store_q[i]));
        end
        done_q = 1'b1;
      end else begin
        decoded_q.push_back(make_result(EV_REPEAT, pos[5:0], val));
      end
    end else begin
      store_q[pos[5:0]] = val;
      if (pos[5:0] > highest_q) highest_q = pos[5:0];
      locked_q = 1'b1;
      decoded_q.push_back(make_result(EV_STORED, pos[5:0], val));
    end
  endtask

  // results that one accepted frame gives
  task automatic decode_frame(input logic [47:0] mac, input logic [11:0] len,
                              input logic [3:0] ch);
    result_t r;
    if (done_q || len > MAX_LEN) begin
      decoded_q.push_back(make_result(EV_NONE, '0, '0));
    end else begin
      case (phase_q)
        HUNTING: begin
          if (len == '0) begin_sync(mac, ch);
        end
        SYNCING: begin
          if (mac == station_q) begin
            if (len == '0) begin
              push_symbol(5'd0);
              phase_q = COLLECTING;
            end else begin
              phase_q   = HUNTING;
              sym_cnt_q = '0;
            end
          end
        end
        COLLECTING: begin
          if (mac == station_q) begin
            if (len == '0) begin_sync(mac, ch);
            else push_symbol(len[4:0]);
          end
        end
        default: begin
          phase_q   = HUNTING;
          sym_cnt_q = '0;
        end
      endcase
      if (sym_cnt_q >= GROUP_LEN) begin
        decode_group();
        phase_q   = HUNTING;
        sym_cnt_q = '0;
      end else begin
        decoded_q.push_back(make_result(EV_NONE, '0, '0));
      end
    end
    r = decoded_q.pop_back();
    r.last = 1'b1;
    decoded_q.push_back(r);
  endtask

  task automatic send_frame(input logic [47:0] mac, input logic [11:0] len,
                            input logic [3:0] ch);
    int gap;
    draw_idle(send_burst, gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    src_mac_i   = mac;
    frame_len_i = len;
    channel_i   = ch;
    do @(posedge clk_i); while (!in_ready_o);
    decode_frame(mac, len, ch);
    n_frames++;
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [47:0] stranger_mac();
    logic [47:0] m;
    m = {16'($urandom), 32'($urandom)};
    if (m == station_q) m[0] = ~m[0];
    return m;
  endfunction

  // occasionally slip in a frame the decoder must ignore
  task automatic maybe_interject(input logic [3:0] ch);
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 0)
        send_frame(stranger_mac(), 12'($urandom_range(0, 16)), 4'($urandom));
      else send_frame(station_q, 12'($urandom_range(17, 4095)), ch);
    end
  endtask

  // two sync frames then four length pairs; broken_pair 1..4 spoils that pair
  task automatic send_group(input logic [7:0] pos, input logic [7:0] val, input logic [3:0] ch,
                            input int broken_pair, input bit may_finish);
    logic [47:0] mac;
    logic [3:0]  nib [4];
    logic [11:0] first_len;
    logic [11:0] second_len;
    mac = locked_q ? station_q : home_mac;
    // keep the crc match for the closing test
    if (!may_finish && broken_pair == 0 && pos < STORE_DEPTH && store_q[pos[5:0]] == val &&
        highest_q > 6'd2 && crc8_over(highest_q) == store_q[highest_q])
      val[0] = ~val[0];
    nib[0] = pos[3:0];
    nib[1] = pos[7:4];
    nib[2] = val[3:0];
    nib[3] = val[7:4];
    // a half-finished sync would swallow the first sync frame
    if (phase_q == SYNCING) send_frame(station_q, 12'd1, ch);
    send_frame(mac, 12'd0, ch);
    maybe_interject(ch);
    send_frame(mac, 12'd0, ch);
    for (int k = 0; k < 4; k++) begin
      first_len  = 12'(nib[k]) + 12'd1;
      second_len = 12'd16 - 12'(nib[k]);
      if (broken_pair == k + 1) second_len = (second_len == 12'd16) ? 12'd1 : second_len + 12'd1;
      maybe_interject(ch);
      send_frame(mac, first_len, ch);
      maybe_interject(ch);
      send_frame(mac, second_len, ch);
    end
  endtask

  task automatic send_noise();
    int          count;
    logic [47:0] mac;
    logic [11:0] len;
    count = $urandom_range(1, 6);
    repeat (count) begin
      mac = ($urandom_range(0, 1) == 0) ? station_q : stranger_mac();
      case ($urandom_range(0, 3))
        0: len = '0;
        1: len = 12'($urandom_range(17, 4095));
        default: len = 12'($urandom_range(1, 16));
      endcase
      send_frame(mac, len, 4'($urandom));
    end
  endtask

  task automatic test_ignored_frames();
    send_frame(48'hFFFF_FFFF_FFFF, 12'hFFF, 4'hF);
    send_frame(home_mac, 12'd17, 4'h0);
    send_frame(48'h0, 12'd16, 4'h0);
    // single sync frame followed by a length: back to hunting
    send_frame(48'h0000_0000_0001, 12'd0, 4'h9);
    send_frame(48'h0000_0000_0001, 12'd7, 4'h9);
    wait_for_results();
  endtask

  task automatic test_store_and_repeat();
    send_group(8'd0, 8'hA5, 4'hF, 0, 1'b0);
    // same value again while the message is still short counts as a store
    send_group(8'd0, 8'hA5, 4'h0, 0, 1'b0);
    send_group(8'd63, 8'hFF, 4'h5, 0, 1'b0);
    send_group(8'd63, 8'hFF, 4'h5, 0, 1'b0);
    wait_for_results();
  endtask

  task automatic test_decode_failures();
    for (int k = 1; k <= 4; k++) send_group(8'($urandom), 8'($urandom), 4'($urandom), k, 1'b0);
    send_group(8'hFF, 8'h00, 4'h7, 0, 1'b0);
    wait_for_results();
  endtask

  task automatic test_other_sender();
    // a stranger may restart sync and move the channel but not take the station
    send_frame(stranger_mac(), 12'd0, 4'h3);
    send_frame(stranger_mac(), 12'd0, 4'h3);
    send_group(8'd5, 8'h3C, 4'hC, 0, 1'b0);
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    int         pick;
    int         goal;
    logic [7:0] pos;
    logic [7:0] val;
    goal = n_frames + RANDOM_FRAMES;
    while (n_frames < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        pos = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(64, 255))
                                          : 8'($urandom_range(0, 63));
        val = 8'($urandom);
        if ($urandom_range(0, 3) == 0) begin
          pos = 8'($urandom_range(0, highest_q));
          val = store_q[pos[5:0]];
        end
        send_group(pos, val, 4'($urandom), 0, 1'b0);
      end else if (pick < 70) begin
        send_group(8'($urandom), 8'($urandom), 4'($urandom), $urandom_range(1, 4), 1'b0);
      end else begin
        send_noise();
      end
      if ($urandom_range(0, 19) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  task automatic test_message_finish();
    logic [5:0] top;
    logic [7:0] crc;
    top = (highest_q < 6'd3) ? 6'd3 : highest_q;
    crc = crc8_over(top);
    send_group({2'b00, top}, crc, 4'hA, 0, 1'b1);
    send_group({2'b00, top}, crc, 4'hA, 0, 1'b1);
    // once the message is out everything is quiet
    send_group(8'd1, 8'h11, 4'h1, 0, 1'b1);
    send_frame(station_q, 12'hFFF, 4'h0);
    wait_for_results();
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always begin : check_results
    result_t want;
    @(posedge clk_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing outstanding, event %0d", $time, event_res_o);
      end else begin
        want = decoded_q.pop_front();
        check_field("event_res", 8'(want.ev), 8'(event_res_o));
        check_field("position", 8'(want.pos), 8'(position_o));
        check_field("value", want.val, value_o);
        check_field("message_length", 8'(want.msg_len), 8'(message_length_o));
        check_field("last", 8'(want.last), 8'(last_o));
        check_field("locked", 8'(want.locked), 8'(locked_o));
        check_field("locked_channel", 8'(want.chan), 8'(locked_channel_o));
      end
      draw_idle(recv_burst, recv_hold);
    end
    @(negedge clk_i);
    if (recv_hold > 0) begin
      out_ready_i = 1'b0;
      recv_hold--;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  initial begin
    home_mac = {16'($urandom), 32'($urandom)};
    reset_shadow();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_ignored_frames();
    test_store_and_repeat();
    test_decode_failures();
    test_other_sender();
    test_random_traffic();
    test_message_finish();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/lccd_pkg.sv
hw/rtl/lccd_ctrl.sv
hw/rtl/lccd_dpath.sv
hw/rtl/length_coded_config_decoder.sv
tb/tb.sv
